FILE: rtl/tcw_pkg.sv
// Shared types and constants of the text console writer.
package tcw_pkg;

   localparam int unsigned COL_W  = 7;
   localparam int unsigned ROW_W  = 5;
   localparam int unsigned CHAR_W = 8;
   localparam int unsigned CELL_W = 16;
   localparam int unsigned OFFS_W = 11;
   // Wide enough for any row times COLUMNS plus column at the largest settings.
   localparam int unsigned FULL_W = 12;

   localparam logic [CHAR_W-1:0] CHAR_BS    = 8'h08;
   localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
   localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0A;
   localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
   localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;

   typedef enum logic [1:0] {
      REQ_PUT_CHAR   = 2'd0,
      REQ_SET_CURSOR = 2'd1,
      REQ_READ_CELL  = 2'd2,
      REQ_CLEAR      = 2'd3
   } req_kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_READ,
      ST_SWEEP,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic [COL_W-1:0] col;
      logic [ROW_W-1:0] row;
      logic             write_cell;
      logic             scroll;
   } cursor_next_type;

endpackage

FILE: rtl/tcw_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module tcw_ram #(
   parameter int unsigned WIDTH = 16,
   parameter int unsigned DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/tcw_addr_unit.sv
// Shared cell address unit: ring row wrap, row times columns, plus column.
module tcw_addr_unit #(
   parameter int unsigned COLUMNS = 80,
   parameter int unsigned ROWS    = 25
) (
   input  logic [tcw_pkg::ROW_W-1:0]        base_row,
   input  logic [tcw_pkg::ROW_W-1:0]        row_offset,
   input  logic [tcw_pkg::COL_W-1:0]        col,
   output logic [$clog2(ROWS*COLUMNS)-1:0]  addr
);

   localparam int unsigned AddrW = $clog2(ROWS * COLUMNS);

   logic [tcw_pkg::ROW_W:0]    row_sum;
   logic [tcw_pkg::ROW_W-1:0]  phys_row;
   logic [tcw_pkg::FULL_W-1:0] full_addr;

   always_comb begin
      row_sum = {1'b0, base_row} + {1'b0, row_offset};
      // Both operands are below ROWS, so one subtraction wraps the ring.
      if (row_sum >= (tcw_pkg::ROW_W + 1)'(ROWS)) begin
         phys_row = tcw_pkg::ROW_W'(row_sum - (tcw_pkg::ROW_W + 1)'(ROWS));
      end else begin
         phys_row = row_sum[tcw_pkg::ROW_W-1:0];
      end
      full_addr = tcw_pkg::FULL_W'(phys_row) * tcw_pkg::FULL_W'(COLUMNS)
                + tcw_pkg::FULL_W'(col);
      addr = full_addr[AddrW-1:0];
   end

endmodule

FILE: rtl/tcw_cursor_unit.sv
// Cursor movement for one put-character request, with wrap and scroll detection.
module tcw_cursor_unit #(
   parameter int unsigned COLUMNS   = 80,
   parameter int unsigned ROWS      = 25,
   parameter int unsigned TAB_WIDTH = 8
) (
   input  logic [tcw_pkg::COL_W-1:0]  cur_col,
   input  logic [tcw_pkg::ROW_W-1:0]  cur_row,
   input  logic [tcw_pkg::CHAR_W-1:0] char_code,
   output tcw_pkg::cursor_next_type   cursor_next
);

   localparam int unsigned TabDepth = 2 ** tcw_pkg::COL_W;

   logic [tcw_pkg::COL_W:0] tab_lut [TabDepth];
   logic [tcw_pkg::COL_W:0] col_new;
   logic [tcw_pkg::ROW_W:0] row_new;
   logic                    row_step;
   logic                    printable;

   // Next tab stop for every column.
   for (genvar i = 0; i < TabDepth; i++) begin : g_tab
      localparam int unsigned TabStop = ((i / TAB_WIDTH) + 1) * TAB_WIDTH;
      assign tab_lut[i] = (tcw_pkg::COL_W + 1)'(TabStop);
   end

   always_comb begin
      col_new   = {1'b0, cur_col};
      row_step  = 1'b0;
      printable = (char_code[7] == 1'b0) && (char_code >= tcw_pkg::CHAR_SPACE);
      cursor_next.write_cell = 1'b0;
      case (char_code)
         tcw_pkg::CHAR_BS: begin
            if (cur_col != '0) begin
               col_new = {1'b0, cur_col} - (tcw_pkg::COL_W + 1)'(1);
            end
         end
         tcw_pkg::CHAR_TAB: begin
            col_new = tab_lut[cur_col];
         end
         tcw_pkg::CHAR_CR: begin
            col_new = '0;
         end
         tcw_pkg::CHAR_LF: begin
            col_new  = '0;
            row_step = 1'b1;
         end
         default: begin
            if (printable) begin
               cursor_next.write_cell = 1'b1;
               col_new = {1'b0, cur_col} + (tcw_pkg::COL_W + 1)'(1);
            end
         end
      endcase
      if (col_new >= (tcw_pkg::COL_W + 1)'(COLUMNS)) begin
         col_new  = '0;
         row_step = 1'b1;
      end
      row_new = {1'b0, cur_row} + (tcw_pkg::ROW_W + 1)'(row_step);
      cursor_next.col = col_new[tcw_pkg::COL_W-1:0];
      if (row_new >= (tcw_pkg::ROW_W + 1)'(ROWS)) begin
         cursor_next.scroll = 1'b1;
         cursor_next.row    = tcw_pkg::ROW_W'(ROWS - 1);
      end else begin
         cursor_next.scroll = 1'b0;
         cursor_next.row    = row_new[tcw_pkg::ROW_W-1:0];
      end
   end

endmodule

FILE: rtl/text_console_writer.sv
// Top level of the text console writer: sequencer, cursor state and screen memory.
//
// A text-mode console engine. The screen of ROWS x COLUMNS character cells
// (character in the low byte, attribute in the high byte) lives in one RAM and
// is treated as a ring: a top-row pointer names the physical row shown as row
// 0, so a scroll only blanks one row and advances the pointer. A request is
// taken at a clock edge where start is high and busy is low; busy then stays
// high until the request is finished. Every request gives exactly one result,
// shown for a single cycle with rsp_strobe high; the receiver cannot stall, so
// it must sample the result ports in that cycle. The order of states is set by
// the one RAM write port and the shared address unit that serves every cell
// access: put character that does not scroll and set cursor go through an
// execute state and then the result state, read cell has a read state between
// them for the registered RAM data, and a put that scrolls or clear screen runs
// a fill sweep over one row or over all ROWS * COLUMNS cells before the result
// state; the fill writes one cell per cycle. After reset the block runs the
// same fill with blanks of attribute 0, holding busy high and giving no result;
// the attribute register may be written during that time. The attribute
// register is written whenever csr_write_enable is high and should only change
// while the block is idle.
module text_console_writer #(
   parameter int unsigned COLUMNS   = 80,
   parameter int unsigned ROWS      = 25,
   parameter int unsigned TAB_WIDTH = 8
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [1:0]                  req_type,
   input  logic [tcw_pkg::CHAR_W-1:0]  req_char_code,
   input  logic [tcw_pkg::ROW_W-1:0]   req_row,
   input  logic [tcw_pkg::COL_W-1:0]   req_column,
   output logic                        rsp_strobe,
   output logic [tcw_pkg::COL_W-1:0]   rsp_cursor_column,
   output logic [tcw_pkg::ROW_W-1:0]   rsp_cursor_row,
   output logic [tcw_pkg::OFFS_W-1:0]  rsp_cursor_offset,
   output logic [tcw_pkg::CELL_W-1:0]  rsp_cell_data,
   input  logic                        csr_write_enable,
   input  logic [7:0]                  csr_write_data
);

   localparam int unsigned CellCount = ROWS * COLUMNS;
   localparam int unsigned AddrW     = $clog2(CellCount);

   // Sequencer state and the request being served.
   tcw_pkg::state_type    state_ff, state_in;
   tcw_pkg::req_kind_type req_kind_ff, req_kind_in;
   logic [tcw_pkg::CHAR_W-1:0] char_ff, char_in;
   logic [tcw_pkg::ROW_W-1:0]  req_row_ff, req_row_in;
   logic [tcw_pkg::COL_W-1:0]  req_col_ff, req_col_in;

   // Console state.
   logic [tcw_pkg::COL_W-1:0]  cur_col_ff, cur_col_in;
   logic [tcw_pkg::ROW_W-1:0]  cur_row_ff, cur_row_in;
   logic [tcw_pkg::ROW_W-1:0]  top_row_ff, top_row_in;
   logic [7:0]                 attr_ff, attr_in;
   logic [tcw_pkg::CELL_W-1:0] cell_ff, cell_in;

   // Fill sweep: walks one row (scroll) or every row (clear and reset).
   logic [tcw_pkg::ROW_W-1:0]  sweep_row_ff, sweep_row_in;
   logic [tcw_pkg::COL_W-1:0]  sweep_col_ff, sweep_col_in;
   logic                       sweep_all_ff, sweep_all_in;
   logic                       sweep_emit_ff, sweep_emit_in;
   logic [tcw_pkg::CELL_W-1:0] fill_ff, fill_in;
   logic                       sweep_done;

   // Shared address unit and memory port.
   logic [tcw_pkg::ROW_W-1:0]  au_base_row;
   logic [tcw_pkg::ROW_W-1:0]  au_row_offset;
   logic [tcw_pkg::COL_W-1:0]  au_col;
   logic [AddrW-1:0]           cell_addr;
   logic                       mem_wr_en;
   logic [tcw_pkg::CELL_W-1:0] mem_wr_data;
   logic [tcw_pkg::CELL_W-1:0] mem_rd_data;

   tcw_pkg::cursor_next_type   cursor_next;
   logic [tcw_pkg::ROW_W-1:0]  clamped_row;
   logic [tcw_pkg::COL_W-1:0]  clamped_col;
   logic [tcw_pkg::FULL_W-1:0] offset_full;
   logic [tcw_pkg::CELL_W-1:0] blank_cell;

   tcw_cursor_unit #(
      .COLUMNS  (COLUMNS),
      .ROWS     (ROWS),
      .TAB_WIDTH(TAB_WIDTH)
   ) u_cursor (
      .cur_col    (cur_col_ff),
      .cur_row    (cur_row_ff),
      .char_code  (char_ff),
      .cursor_next(cursor_next)
   );

   tcw_addr_unit #(
      .COLUMNS(COLUMNS),
      .ROWS   (ROWS)
   ) u_addr (
      .base_row  (au_base_row),
      .row_offset(au_row_offset),
      .col       (au_col),
      .addr      (cell_addr)
   );

   tcw_ram #(
      .WIDTH(tcw_pkg::CELL_W),
      .DEPTH(CellCount)
   ) u_screen (
      .clock  (clock),
      .wr_en  (mem_wr_en),
      .wr_addr(cell_addr),
      .wr_data(mem_wr_data),
      .rd_addr(cell_addr),
      .rd_data(mem_rd_data)
   );

   // Requested coordinates are clamped to the screen as they are taken in.
   always_comb begin
      if (req_row > tcw_pkg::ROW_W'(ROWS - 1)) begin
         clamped_row = tcw_pkg::ROW_W'(ROWS - 1);
      end else begin
         clamped_row = req_row;
      end
      if (req_column > tcw_pkg::COL_W'(COLUMNS - 1)) begin
         clamped_col = tcw_pkg::COL_W'(COLUMNS - 1);
      end else begin
         clamped_col = req_column;
      end
   end

   assign blank_cell = {attr_ff, tcw_pkg::CHAR_SPACE};

   // The sweep ends on the last column of its last row.
   assign sweep_done = (sweep_col_ff == tcw_pkg::COL_W'(COLUMNS - 1)) &&
                       (!sweep_all_ff || (sweep_row_ff == tcw_pkg::ROW_W'(ROWS - 1)));

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tcw_pkg::ST_IDLE: begin
            if (start) begin
               state_in = tcw_pkg::ST_EXEC;
            end
         end
         tcw_pkg::ST_EXEC: begin
            unique case (req_kind_ff)
               tcw_pkg::REQ_PUT_CHAR: begin
                  state_in = cursor_next.scroll ? tcw_pkg::ST_SWEEP : tcw_pkg::ST_RESP;
               end
               tcw_pkg::REQ_SET_CURSOR: state_in = tcw_pkg::ST_RESP;
               tcw_pkg::REQ_READ_CELL:  state_in = tcw_pkg::ST_READ;
               tcw_pkg::REQ_CLEAR:      state_in = tcw_pkg::ST_SWEEP;
               default:                 state_in = tcw_pkg::ST_RESP;
            endcase
         end
         tcw_pkg::ST_READ: begin
            state_in = tcw_pkg::ST_RESP;
         end
         tcw_pkg::ST_SWEEP: begin
            if (sweep_done) begin
               state_in = sweep_emit_ff ? tcw_pkg::ST_RESP : tcw_pkg::ST_IDLE;
            end
         end
         tcw_pkg::ST_RESP: begin
            state_in = tcw_pkg::ST_IDLE;
         end
         default: begin
            state_in = tcw_pkg::ST_IDLE;
         end
      endcase
   end

   // Datapath and memory controls.
   always_comb begin
      req_kind_in   = req_kind_ff;
      char_in       = char_ff;
      req_row_in    = req_row_ff;
      req_col_in    = req_col_ff;
      cur_col_in    = cur_col_ff;
      cur_row_in    = cur_row_ff;
      top_row_in    = top_row_ff;
      cell_in       = cell_ff;
      sweep_row_in  = sweep_row_ff;
      sweep_col_in  = sweep_col_ff;
      sweep_all_in  = sweep_all_ff;
      sweep_emit_in = sweep_emit_ff;
      fill_in       = fill_ff;
      attr_in       = csr_write_enable ? csr_write_data : attr_ff;

      // By default the address unit points at the cursor, or at the
      // requested cell for a read.
      au_base_row   = top_row_ff;
      au_row_offset = (req_kind_ff == tcw_pkg::REQ_READ_CELL) ? req_row_ff : cur_row_ff;
      au_col        = (req_kind_ff == tcw_pkg::REQ_READ_CELL) ? req_col_ff : cur_col_ff;
      mem_wr_en     = 1'b0;
      mem_wr_data   = {attr_ff, char_ff};

      unique case (state_ff)
         tcw_pkg::ST_IDLE: begin
            if (start) begin
               req_kind_in = tcw_pkg::req_kind_type'(req_type);
               char_in     = req_char_code;
               req_row_in  = clamped_row;
               req_col_in  = clamped_col;
            end
         end
         tcw_pkg::ST_EXEC: begin
            cell_in = '0;
            unique case (req_kind_ff)
               tcw_pkg::REQ_PUT_CHAR: begin
                  mem_wr_en  = cursor_next.write_cell;
                  cur_col_in = cursor_next.col;
                  cur_row_in = cursor_next.row;
                  // A scroll blanks the physical row that is leaving the top.
                  sweep_row_in  = top_row_ff;
                  sweep_col_in  = '0;
                  sweep_all_in  = 1'b0;
                  sweep_emit_in = 1'b1;
                  fill_in       = blank_cell;
               end
               tcw_pkg::REQ_SET_CURSOR: begin
                  cur_col_in = req_col_ff;
                  cur_row_in = req_row_ff;
               end
               tcw_pkg::REQ_READ_CELL: begin
                  // The read address is presented now; data arrives next cycle.
               end
               tcw_pkg::REQ_CLEAR: begin
                  cur_col_in    = '0;
                  cur_row_in    = '0;
                  top_row_in    = '0;
                  sweep_row_in  = '0;
                  sweep_col_in  = '0;
                  sweep_all_in  = 1'b1;
                  sweep_emit_in = 1'b1;
                  fill_in       = blank_cell;
               end
               default: begin
               end
            endcase
         end
         tcw_pkg::ST_READ: begin
            cell_in = mem_rd_data;
         end
         tcw_pkg::ST_SWEEP: begin
            au_base_row   = sweep_row_ff;
            au_row_offset = '0;
            au_col        = sweep_col_ff;
            mem_wr_en     = 1'b1;
            mem_wr_data   = fill_ff;
            if (sweep_col_ff == tcw_pkg::COL_W'(COLUMNS - 1)) begin
               sweep_col_in = '0;
               if (sweep_all_ff && !sweep_done) begin
                  sweep_row_in = sweep_row_ff + tcw_pkg::ROW_W'(1);
               end
            end else begin
               sweep_col_in = sweep_col_ff + tcw_pkg::COL_W'(1);
            end
            // A finished scroll moves the ring on by one row.
            if (sweep_done && !sweep_all_ff) begin
               if (top_row_ff == tcw_pkg::ROW_W'(ROWS - 1)) begin
                  top_row_in = '0;
               end else begin
                  top_row_in = top_row_ff + tcw_pkg::ROW_W'(1);
               end
            end
         end
         tcw_pkg::ST_RESP: begin
         end
         default: begin
         end
      endcase
   end

   // Control state. After reset the sequencer fills the whole screen with
   // plain blanks before the first request is taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= tcw_pkg::ST_SWEEP;
         cur_col_ff    <= '0;
         cur_row_ff    <= '0;
         top_row_ff    <= '0;
         attr_ff       <= '0;
         sweep_row_ff  <= '0;
         sweep_col_ff  <= '0;
         sweep_all_ff  <= 1'b1;
         sweep_emit_ff <= 1'b0;
         fill_ff       <= {8'h00, tcw_pkg::CHAR_SPACE};
      end else begin
         state_ff      <= state_in;
         cur_col_ff    <= cur_col_in;
         cur_row_ff    <= cur_row_in;
         top_row_ff    <= top_row_in;
         attr_ff       <= attr_in;
         sweep_row_ff  <= sweep_row_in;
         sweep_col_ff  <= sweep_col_in;
         sweep_all_ff  <= sweep_all_in;
         sweep_emit_ff <= sweep_emit_in;
         fill_ff       <= fill_in;
      end
   end

   // Request payload and read data need no reset.
   always_ff @(posedge clock) begin
      req_kind_ff <= req_kind_in;
      char_ff     <= char_in;
      req_row_ff  <= req_row_in;
      req_col_ff  <= req_col_in;
      cell_ff     <= cell_in;
   end

   // Result: the cursor and its linear offset for the display controller.
   assign offset_full = tcw_pkg::FULL_W'(cur_row_ff) * tcw_pkg::FULL_W'(COLUMNS)
                      + tcw_pkg::FULL_W'(cur_col_ff);

   assign busy              = (state_ff != tcw_pkg::ST_IDLE);
   assign rsp_strobe        = (state_ff == tcw_pkg::ST_RESP);
   assign rsp_cursor_column = cur_col_ff;
   assign rsp_cursor_row    = cur_row_ff;
   assign rsp_cursor_offset = offset_full[tcw_pkg::OFFS_W-1:0];
   assign rsp_cell_data     = cell_ff;

   // A taken request keeps the block busy until its result has gone out.
   a_busy_after_accept : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy did not rise after a request was taken");

   // The result strobe always falls again after each pulse; it is never held.
   a_single_strobe : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held for more than one cycle");

   // The reported cursor always lies on the screen.
   a_cursor_on_screen : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ((rsp_cursor_row < ROWS) && (rsp_cursor_column < COLUMNS)))
      else $error("reported cursor lies outside the screen");

   // Only a read request returns cell data.
   a_cell_only_on_read : assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (req_kind_ff != tcw_pkg::REQ_READ_CELL)) |-> (rsp_cell_data == '0))
      else $error("cell data returned for a request that is not a read");

endmodule

FILE: verif/tb.sv
// Self-checking testbench for the text console writer: directed cases, then random traffic.
`timescale 1ns / 100ps

module tb;

   // The block is built with its default geometry; the model of the screen
   // below uses the same numbers.
   localparam int NUM_COLS  = 80;
   localparam int NUM_ROWS  = 25;
   localparam int TAB_STOP  = 8;
   localparam int NUM_CELLS = NUM_COLS * NUM_ROWS;
   localparam int MAX_SHOWN = 10;

   // One result as the block should report it.
   typedef struct {
      logic [tcw_pkg::COL_W-1:0]  col;
      logic [tcw_pkg::ROW_W-1:0]  row;
      logic [tcw_pkg::OFFS_W-1:0] offset;
      logic [tcw_pkg::CELL_W-1:0] cell_word;
   } cursor_report_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       start = 1'b0;
   logic                       busy;
   logic [1:0]                 req_type = tcw_pkg::REQ_PUT_CHAR;
   logic [tcw_pkg::CHAR_W-1:0] req_char_code = '0;
   logic [tcw_pkg::ROW_W-1:0]  req_row = '0;
   logic [tcw_pkg::COL_W-1:0]  req_column = '0;
   logic                       rsp_strobe;
   logic [tcw_pkg::COL_W-1:0]  rsp_cursor_column;
   logic [tcw_pkg::ROW_W-1:0]  rsp_cursor_row;
   logic [tcw_pkg::OFFS_W-1:0] rsp_cursor_offset;
   logic [tcw_pkg::CELL_W-1:0] rsp_cell_data;
   logic                       csr_write_enable = 1'b0;
   logic [7:0]                 csr_write_data = '0;

   // Our own copy of the console: the physical screen, the ring pointer that
   // names the physical row shown at the top, the cursor and the attribute.
   logic [tcw_pkg::CELL_W-1:0] screen_copy [NUM_CELLS];
   int                         top_line;
   int                         cursor_col;
   int                         cursor_row;
   logic [7:0]                 text_attr;

   cursor_report_type pending_reports[$];

   int mismatch_count   = 0;
   int request_count    = 0;
   int put_count        = 0;
   int read_count       = 0;
   int scroll_count     = 0;
   int clear_count      = 0;
   int attr_write_count = 0;
   int random_clears_left;

   text_console_writer #(
      .COLUMNS   (NUM_COLS),
      .ROWS      (NUM_ROWS),
      .TAB_WIDTH (TAB_STOP)
   ) u_dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_type          (req_type),
      .req_char_code     (req_char_code),
      .req_row           (req_row),
      .req_column        (req_column),
      .rsp_strobe        (rsp_strobe),
      .rsp_cursor_column (rsp_cursor_column),
      .rsp_cursor_row    (rsp_cursor_row),
      .rsp_cursor_offset (rsp_cursor_offset),
      .rsp_cell_data     (rsp_cell_data),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------------
   // Screen model
   // ---------------------------------------------------------------------

   // Maps a visible row and a column onto the physical cell, going round the
   // ring from the current top line.
   function automatic int cell_index(input int vis_row, input int col);
      return ((top_line + vis_row) % NUM_ROWS) * NUM_COLS + col;
   endfunction

   // Blanks a whole physical row with the current attribute and moves the top
   // of the ring down by one, which is how the screen scrolls up a line.
   task automatic scroll_screen();
      int base;
      base = top_line * NUM_COLS;
      for (int c = 0; c < NUM_COLS; c++) begin
         screen_copy[base + c] = {text_attr, tcw_pkg::CHAR_SPACE};
      end
      top_line = (top_line + 1) % NUM_ROWS;
      scroll_count++;
   endtask

   // A put character request: control codes move the cursor, printable codes
   // are written and advance it, everything else leaves the screen alone.
   task automatic put_character(input logic [tcw_pkg::CHAR_W-1:0] code);
      if (code == tcw_pkg::CHAR_BS) begin
         if (cursor_col != 0) cursor_col--;
      end else if (code == tcw_pkg::CHAR_TAB) begin
         cursor_col = (cursor_col / TAB_STOP + 1) * TAB_STOP;
      end else if (code == tcw_pkg::CHAR_CR) begin
         cursor_col = 0;
      end else if (code == tcw_pkg::CHAR_LF) begin
         cursor_col = 0;
         cursor_row++;
      end else if (code >= tcw_pkg::CHAR_SPACE && code < 8'h80) begin
         screen_copy[cell_index(cursor_row, cursor_col)] = {text_attr, code};
         cursor_col++;
      end
      // Running off the right edge wraps to the next line; running off the
      // bottom scrolls and keeps the cursor on the last line.
      if (cursor_col >= NUM_COLS) begin
         cursor_col = 0;
         cursor_row++;
      end
      if (cursor_row >= NUM_ROWS) begin
         scroll_screen();
         cursor_row = NUM_ROWS - 1;
      end
   endtask

   // Applies one accepted request to the model and queues the result that the
   // block has to report for it.
   task automatic predict_report(input tcw_pkg::req_kind_type kind,
                                 input logic [tcw_pkg::CHAR_W-1:0] code,
                                 input logic [tcw_pkg::ROW_W-1:0] row_in,
                                 input logic [tcw_pkg::COL_W-1:0] col_in);
      int                row_c;
      int                col_c;
      cursor_report_type report;
      // Coordinates beyond the screen are pulled back to the last row/column.
      row_c = (row_in > NUM_ROWS - 1) ? NUM_ROWS - 1 : row_in;
      col_c = (col_in > NUM_COLS - 1) ? NUM_COLS - 1 : col_in;
      report.cell_word = '0;
      case (kind)
         tcw_pkg::REQ_PUT_CHAR: begin
            put_character(code);
            put_count++;
         end
         tcw_pkg::REQ_SET_CURSOR: begin
            cursor_row = row_c;
            cursor_col = col_c;
         end
         tcw_pkg::REQ_READ_CELL: begin
            report.cell_word = screen_copy[cell_index(row_c, col_c)];
            read_count++;
         end
         tcw_pkg::REQ_CLEAR: begin
            for (int i = 0; i < NUM_CELLS; i++)
               screen_copy[i] = {text_attr, tcw_pkg::CHAR_SPACE};
            cursor_col = 0;
            cursor_row = 0;
            top_line = 0;
            clear_count++;
         end
      endcase
      report.col    = tcw_pkg::COL_W'(cursor_col);
      report.row    = tcw_pkg::ROW_W'(cursor_row);
      report.offset = tcw_pkg::OFFS_W'(cursor_row * NUM_COLS + cursor_col);
      pending_reports.push_back(report);
      request_count++;
   endtask

   // ---------------------------------------------------------------------
   // Driving
   // ---------------------------------------------------------------------

   // Presents one request after an optional idle gap and returns at the edge
   // where it was taken. Start is left high so that a following request with
   // no gap goes straight in; the gap or a drain lowers it.
   task automatic send_request(input tcw_pkg::req_kind_type kind,
                               input logic [tcw_pkg::CHAR_W-1:0] code,
                               input logic [tcw_pkg::ROW_W-1:0] row_in,
                               input logic [tcw_pkg::COL_W-1:0] col_in, input int gap);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start         <= 1'b1;
      req_type      <= kind;
      req_char_code <= code;
      req_row       <= row_in;
      req_column    <= col_in;
      do @(posedge clock); while (busy);
      predict_report(kind, code, row_in, col_in);
   endtask

   // Stops sending and waits until every queued result has been seen, so the
   // block is idle afterwards.
   task automatic wait_for_reports();
      start <= 1'b0;
      do @(posedge clock); while (pending_reports.size() != 0);
   endtask

   // Writes the attribute register; only called while the block is idle.
   task automatic write_attribute(input logic [7:0] value);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      text_attr = value;
      attr_write_count++;
   endtask

   // ---------------------------------------------------------------------
   // Result checking
   // ---------------------------------------------------------------------

   task automatic note_field(input string label, input int want, input int got);
      if (want != got) begin
         mismatch_count++;
         if (mismatch_count <= MAX_SHOWN)
            $display("%0t: %s mismatch, expected %0d (0x%0h), got %0d (0x%0h)",
                     $realtime, label, want, want, got, got);
      end
   endtask

   // The receiver cannot hold results off, so every strobe is compared with
   // the oldest outstanding prediction in the cycle it appears.
   always @(posedge clock) begin
      cursor_report_type want;
      if (!reset && rsp_strobe) begin
         if (pending_reports.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_SHOWN)
               $display("%0t: result with no request outstanding", $realtime);
         end else begin
            want = pending_reports.pop_front();
            note_field("cursor_column", want.col, rsp_cursor_column);
            note_field("cursor_row", want.row, rsp_cursor_row);
            note_field("cursor_offset", want.offset, rsp_cursor_offset);
            note_field("cell_data", want.cell_word, rsp_cell_data);
         end
      end
   end

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // The screen straight after the power-up fill: corner cells must be blank
   // with attribute 0, and out-of-range coordinates must be clamped.
   task automatic test_power_up_screen();
      send_request(tcw_pkg::REQ_READ_CELL, 8'h00, 5'd0, 7'd0, 0);
      send_request(tcw_pkg::REQ_READ_CELL, 8'hFF, 5'd31, 7'd127, 0);
      send_request(tcw_pkg::REQ_SET_CURSOR, 8'h00, 5'd31, 7'd127, 0);
      send_request(tcw_pkg::REQ_SET_CURSOR, 8'hFF, 5'd0, 7'd0, 0);
   endtask

   // Every class of character code on the first line: printable codes, including
   // the top of the range, backspace mid-line and at column 0, tab, CR, LF, and
   // codes that must be ignored (low controls and the top half of the byte).
   task automatic test_control_codes();
      wait_for_reports();
      write_attribute(8'hFF);
      send_request(tcw_pkg::REQ_PUT_CHAR, 8'h41, 5'd0, 7'd0, 0);
      send_request(tcw_pkg::REQ_PUT_CHAR, 8'h7F, 5'd31, 7'd127, 0);
      send_request(tcw_pkg::REQ_PUT_CHAR, tcw_pkg::CHAR_BS, 5'd0, 7'd0, 0);
      send_request(tcw_pkg::REQ_PUT_CHAR, tcw_pkg::CHAR_TAB, 5'd0, 7'd0, 0);
      send_request(tcw_pkg::REQ_PUT_CHAR, tcw_pkg::CHAR_CR, 5'd0, 7'd0, 0);
      send_request(tcw_pkg::REQ_PUT_CHAR, tcw_pkg::CHAR_BS, 5'd0, 7'd0, 0);
      send_request(tcw_pkg::REQ_PUT_CHAR, 8'h00, 5'd0, 7'd0, 0);
      send_request(tcw_pkg::REQ_PUT_CHAR, 8'h1F, 5'd0, 7'd0, 0);
      send_request(tcw_pkg::REQ_PUT_CHAR, 8'h80, 5'd0, 7'd0, 0);
      send_request(tcw_pkg::REQ_PUT_CHAR, 8'hFF, 5'd0, 7'd0, 0);
      send_request(tcw_pkg::REQ_PUT_CHAR, tcw_pkg::CHAR_LF, 5'd0, 7'd0, 0);
      send_request(tcw_pkg::REQ_READ_CELL, 8'h00, 5'd0, 7'd0, 0);
      send_request(tcw_pkg::REQ_READ_CELL, 8'h00, 5'd0, 7'd1, 0);
   endtask

   // Writing into the very last cell wraps and scrolls; a tab near the right
   // edge does the same without writing anything.
   task automatic test_wrap_and_scroll();
      send_request(tcw_pkg::REQ_SET_CURSOR, 8'h00, 5'd24, 7'd79, 0);
      send_request(tcw_pkg::REQ_PUT_CHAR, 8'h7E, 5'd0, 7'd0, 0);
      send_request(tcw_pkg::REQ_READ_CELL, 8'h00, 5'd23, 7'd79, 0);
      send_request(tcw_pkg::REQ_READ_CELL, 8'h00, 5'd24, 7'd0, 0);
      send_request(tcw_pkg::REQ_SET_CURSOR, 8'h00, 5'd24, 7'd75, 0);
      send_request(tcw_pkg::REQ_PUT_CHAR, tcw_pkg::CHAR_TAB, 5'd0, 7'd0, 0);
   endtask

   // Clearing with a fresh attribute must home the cursor and blank the screen;
   // the last cell is read back.
   task automatic test_clear_screen();
      wait_for_reports();
      write_attribute(8'h5A);
      send_request(tcw_pkg::REQ_CLEAR, 8'h00, 5'd0, 7'd0, 0);
      send_request(tcw_pkg::REQ_READ_CELL, 8'h00, 5'd24, 7'd79, 0);
   endtask

   // Picks a character that looks like terminal output: mostly printable text
   // with line controls mixed in and a little noise that must be ignored.
   function automatic logic [tcw_pkg::CHAR_W-1:0] pick_char();
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 68) return tcw_pkg::CHAR_W'($urandom_range(8'h20, 8'h7F));
      if (sel < 76) return tcw_pkg::CHAR_LF;
      if (sel < 79) return tcw_pkg::CHAR_CR;
      if (sel < 84) return tcw_pkg::CHAR_TAB;
      if (sel < 90) return tcw_pkg::CHAR_BS;
      if (sel < 95) return tcw_pkg::CHAR_W'($urandom_range(8'h00, 8'h1F));
      return tcw_pkg::CHAR_W'($urandom_range(8'h80, 8'hFF));
   endfunction

   // One phase of random traffic under a given attribute. Idle gaps are drawn
   // per request, but some stretches of sixteen run back to back. Reads favour
   // the cursor's own line so that freshly written text is read back.
   task automatic test_random_traffic(input int count, input logic [7:0] attr);
      tcw_pkg::req_kind_type      kind;
      logic [tcw_pkg::CHAR_W-1:0] code;
      logic [tcw_pkg::ROW_W-1:0]  row_in;
      logic [tcw_pkg::COL_W-1:0]  col_in;
      int                         sel;
      int                         gap;
      bit                         back_to_back;
      wait_for_reports();
      write_attribute(attr);
      back_to_back = 1'b0;
      for (int i = 0; i < count; i++) begin
         if (i % 16 == 0) back_to_back = ($urandom_range(0, 3) == 0);
         gap    = back_to_back ? 0 : $urandom_range(0, 13);
         code   = tcw_pkg::CHAR_W'($urandom);
         row_in = tcw_pkg::ROW_W'($urandom);
         col_in = tcw_pkg::COL_W'($urandom);
         sel    = $urandom_range(0, 99);
         if (sel < 58) begin
            kind = tcw_pkg::REQ_PUT_CHAR;
            code = pick_char();
         end else if (sel < 72) begin
            kind = tcw_pkg::REQ_SET_CURSOR;
         end else if (sel < 98 || random_clears_left == 0) begin
            kind = tcw_pkg::REQ_READ_CELL;
            if ($urandom_range(0, 1) == 1) begin
               row_in = tcw_pkg::ROW_W'(cursor_row);
               col_in = tcw_pkg::COL_W'($urandom_range(0, NUM_COLS - 1));
            end
         end else begin
            kind = tcw_pkg::REQ_CLEAR;
            random_clears_left--;
         end
         send_request(kind, code, row_in, col_in, gap);
      end
   endtask

   // ---------------------------------------------------------------------
   // Sequence of the run
   // ---------------------------------------------------------------------

   initial begin
      for (int i = 0; i < NUM_CELLS; i++) screen_copy[i] = {8'h00, tcw_pkg::CHAR_SPACE};
      top_line   = 0;
      cursor_col = 0;
      cursor_row = 0;
      text_attr  = 8'h00;
      random_clears_left = 14;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // The first request simply waits out the power-up fill on busy.
      test_power_up_screen();
      test_control_codes();
      test_wrap_and_scroll();
      test_clear_screen();
      // Each phase starts from an idle block, which also exercises the sender
      // pausing until everything outstanding has come back.
      test_random_traffic(185, 8'h00);
      test_random_traffic(185, 8'hFF);
      test_random_traffic(185, 8'h1E);
      test_random_traffic(185, 8'hF0);
      test_random_traffic(185, 8'($urandom));

      wait_for_reports();
      // A short quiet spell catches any stray result after the last one.
      repeat (100) @(posedge clock);

      $display("Ran %0d requests: %0d characters put, %0d cell reads, %0d screen clears.",
               request_count, put_count, read_count, clear_count);
      $display("The screen scrolled %0d times under %0d attribute settings.",
               scroll_count, attr_write_count);
      if (pending_reports.size() != 0)
         $display("%0d results never arrived", pending_reports.size());
      if (mismatch_count == 0 && pending_reports.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("%0d mismatches in total", mismatch_count);
         $display("CHECK FAILED");
      end
      $finish;
   end

   // Watchdog: a correct run needs well under a fifth of this time.
   initial begin
      #8_000_000;
      $display("Timed out with %0d results outstanding", pending_reports.size());
      $display("CHECK FAILED");
      $finish;
   end

endmodule

FILE: sim.f
rtl/tcw_pkg.sv
rtl/tcw_ram.sv
rtl/tcw_addr_unit.sv
rtl/tcw_cursor_unit.sv
rtl/text_console_writer.sv
verif/tb.sv
